// ===== hdl/ppghr_pkg.sv =====
`default_nettype none

package ppghr_pkg;

    // window depths and fixed point
    localparam int MEAN_DEPTH = 16;
    localparam int BPM_DEPTH  = 10;
    localparam int FRAC_BITS  = 8;

    localparam int MEAN_PW  = $clog2(MEAN_DEPTH);
    localparam int MEAN_FW  = $clog2(MEAN_DEPTH + 1);
    localparam int MEAN_SW  = 32 + MEAN_PW;
    localparam int BPM_PW   = (BPM_DEPTH > 1) ? $clog2(BPM_DEPTH) : 1;
    localparam int BPM_FW   = $clog2(BPM_DEPTH + 1);
    localparam int BPM_SW   = 24 + BPM_PW;
    localparam int DIV_NW   = (MEAN_SW > 36) ? MEAN_SW : 36;
    localparam int DIV_CW   = $clog2(DIV_NW);

    // low-pass coefficients, Q1.30
    localparam logic signed [31:0] LP_C1 = 32'sd263321519;
    localparam logic signed [31:0] LP_C2 = 32'sd547098786;
    localparam logic [DIV_NW-1:0] BPM_NUM = DIV_NW'(64'd60000 << FRAC_BITS);

    // tracker modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_UP   = 2'd1;
    localparam logic [1:0] MODE_DOWN = 2'd2;

    // register indexes
    localparam logic [2:0] REG_DC_ALPHA   = 3'd0;
    localparam logic [2:0] REG_THRESHOLD  = 3'd1;
    localparam logic [2:0] REG_MARGIN     = 3'd2;
    localparam logic [2:0] REG_PERIOD     = 3'd3;
    localparam logic [2:0] REG_RED_START  = 3'd4;
    localparam logic [2:0] REG_IR_CURRENT = 3'd5;

    localparam logic [3:0] RED_MAX   = 4'd15;
    localparam logic [3:0] RED_RESET = 4'd8;

    localparam int OUT_W  = 224;

    typedef struct packed {
        logic load_in;
        logic mul_ir;
        logic add_ir;
        logic add_red;
        logic div_mean;
        logic mean_fix;
        logic lp1;
        logic lp2;
        logic lp3;
        logic card;
        logic track;
        logic div_bpm;
        logic bpm_upd;
        logic div_avg;
        logic avg_fix;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic peak;
        logic out_free;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ppghr_div.sv =====
`default_nettype none

module ppghr_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [ppghr_pkg::DIV_NW-1:0]    dividend,
    input  wire logic [31:0]                     divisor,
    output logic                                 done,
    output logic [ppghr_pkg::DIV_NW-1:0]         quotient,
    output logic                                 rem_nz
);

    logic [ppghr_pkg::DIV_NW-1:0] quo_reg, quo_next;
    logic [31:0]                  rem_reg, rem_next;
    logic [31:0]                  dvs_reg;
    logic [ppghr_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [32:0]                  shifted;

    // restoring divider, one quotient bit a cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[ppghr_pkg::DIV_NW-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = 32'(shifted - {1'b0, dvs_reg});
                quo_next = {quo_reg[ppghr_pkg::DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[ppghr_pkg::DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ppghr_pkg::DIV_CW'(ppghr_pkg::DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

`default_nettype wire

// ===== hdl/ppghr_ctrl.sv =====
`default_nettype none

module ppghr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ppghr_pkg::stat_t  stat,
    output ppghr_pkg::cmd_t        cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_MULIR = 5'd1;
    localparam logic [4:0] ST_ADDIR = 5'd2;
    localparam logic [4:0] ST_ADDRD = 5'd3;
    localparam logic [4:0] ST_DIVM  = 5'd4;
    localparam logic [4:0] ST_WAITM = 5'd5;
    localparam logic [4:0] ST_MFIX  = 5'd6;
    localparam logic [4:0] ST_LP1   = 5'd7;
    localparam logic [4:0] ST_LP2   = 5'd8;
    localparam logic [4:0] ST_LP3   = 5'd9;
    localparam logic [4:0] ST_CARD  = 5'd10;
    localparam logic [4:0] ST_TRACK = 5'd11;
    localparam logic [4:0] ST_DIVB  = 5'd12;
    localparam logic [4:0] ST_WAITB = 5'd13;
    localparam logic [4:0] ST_BUPD  = 5'd14;
    localparam logic [4:0] ST_DIVA  = 5'd15;
    localparam logic [4:0] ST_WAITA = 5'd16;
    localparam logic [4:0] ST_AFIX  = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = ST_MULIR;
            end
            ST_MULIR:
            begin
                cmd.mul_ir = 1'b1;
                state_next = ST_ADDIR;
            end
            ST_ADDIR:
            begin
                cmd.add_ir = 1'b1;
                state_next = ST_ADDRD;
            end
            ST_ADDRD:
            begin
                cmd.add_red = 1'b1;
                state_next  = ST_DIVM;
            end
            ST_DIVM:
            begin
                cmd.div_mean = 1'b1;
                state_next   = ST_WAITM;
            end
            ST_WAITM:
            begin
                if (stat.div_done)
                    state_next = ST_MFIX;
            end
            ST_MFIX:
            begin
                cmd.mean_fix = 1'b1;
                state_next   = ST_LP1;
            end
            ST_LP1:
            begin
                cmd.lp1    = 1'b1;
                state_next = ST_LP2;
            end
            ST_LP2:
            begin
                cmd.lp2    = 1'b1;
                state_next = ST_LP3;
            end
            ST_LP3:
            begin
                cmd.lp3    = 1'b1;
                state_next = ST_CARD;
            end
            ST_CARD:
            begin
                cmd.card   = 1'b1;
                state_next = ST_TRACK;
            end
            ST_TRACK:
            begin
                cmd.track  = 1'b1;
                state_next = stat.peak ? ST_DIVB : ST_OUT;
            end
            ST_DIVB:
            begin
                cmd.div_bpm = 1'b1;
                state_next  = ST_WAITB;
            end
            ST_WAITB:
            begin
                if (stat.div_done)
                    state_next = ST_BUPD;
            end
            ST_BUPD:
            begin
                cmd.bpm_upd = 1'b1;
                state_next  = ST_DIVA;
            end
            ST_DIVA:
            begin
                cmd.div_avg = 1'b1;
                state_next  = ST_WAITA;
            end
            ST_WAITA:
            begin
                if (stat.div_done)
                    state_next = ST_AFIX;
            end
            ST_AFIX:
            begin
                cmd.avg_fix = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hdl/ppghr_dpath.sv =====
`default_nettype none

module ppghr_dpath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ppghr_pkg::cmd_t                cmd,
    output ppghr_pkg::stat_t                    stat,
    input  wire logic [63:0]                    in_data,
    input  wire logic                           cfg_we,
    input  wire logic [2:0]                     cfg_idx,
    input  wire logic [30:0]                    cfg_wdata,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ppghr_pkg::OUT_W-1:0]         out_data
);

    // configuration
    logic [15:0] alpha_reg;
    logic [23:0] thresh_reg;
    logic [30:0] margin_reg;
    logic [15:0] period_reg;
    logic [3:0]  ir_cur_reg;

    // sample and signal state
    logic [15:0]        raw_ir_reg, raw_red_reg;
    logic [31:0]        time_reg;
    logic signed [31:0] ir_dc_reg, red_dc_reg, ir_ac_reg, red_ac_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic signed [31:0] mean_win_reg [ppghr_pkg::MEAN_DEPTH];
    logic signed [ppghr_pkg::MEAN_SW-1:0] mean_sum_reg;
    logic [ppghr_pkg::MEAN_PW-1:0] mean_pos_reg;
    logic [ppghr_pkg::MEAN_FW-1:0] mean_fill_reg;
    logic signed [31:0] md_reg, lp_prev_reg, lp_cur_reg, card_reg, prev_lvl_reg;
    logic [1:0]         mode_reg;
    logic [31:0]        beat_reg, prior_reg, dur_reg, last_chk_reg;
    logic [23:0]        bpm_win_reg [ppghr_pkg::BPM_DEPTH];
    logic [ppghr_pkg::BPM_PW-1:0] bpm_pos_reg;
    logic [ppghr_pkg::BPM_FW-1:0] bpm_fill_reg;
    logic [ppghr_pkg::BPM_SW-1:0] bpm_sum_reg;
    logic [23:0]        avg_bpm_reg, peak_reg;
    logic [3:0]         red_cur_reg;
    logic               pulse_reg, changed_reg;
    logic               out_valid_reg;
    logic [ppghr_pkg::OUT_W-1:0] out_data_reg;

    // shared multiplier operands
    logic signed [31:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = ir_dc_reg;
        mul_b = {16'd0, alpha_reg};
        if (cmd.add_ir)
            mul_a = red_dc_reg;
        else if (cmd.lp1)
        begin
            mul_a = md_reg;
            mul_b = ppghr_pkg::LP_C1;
        end
        else if (cmd.lp2)
        begin
            mul_a = lp_prev_reg;
            mul_b = ppghr_pkg::LP_C2;
        end
    end

    // dc removal step, shared by both channels
    logic signed [31:0] dc_w, dc_nw, dc_ac;
    logic [15:0]        dc_raw;
    logic signed [63:0] dc_sum;
    always_comb
    begin
        dc_w   = cmd.add_ir ? ir_dc_reg : red_dc_reg;
        dc_raw = cmd.add_ir ? raw_ir_reg : raw_red_reg;
        dc_sum = $signed(64'({dc_raw, ppghr_pkg::FRAC_BITS'(0)})) + (prod_reg >>> 16);
        dc_nw  = ppghr_pkg::sat32(dc_sum);
        dc_ac  = ppghr_pkg::sat32(64'(dc_nw) - 64'(dc_w));
    end

    // moving mean update
    logic signed [ppghr_pkg::MEAN_SW:0] msum_ext;
    assign msum_ext = (ppghr_pkg::MEAN_SW+1)'(mean_sum_reg)
                    - (ppghr_pkg::MEAN_SW+1)'(mean_win_reg[mean_pos_reg])
                    + (ppghr_pkg::MEAN_SW+1)'(ir_ac_reg);

    // floor division fixup of the mean
    logic                          m_neg;
    logic [ppghr_pkg::DIV_NW-1:0]  m_abs;
    logic signed [ppghr_pkg::DIV_NW+1:0] m_avg;
    logic                          div_done, div_rnz;
    logic [ppghr_pkg::DIV_NW-1:0]  div_q;
    always_comb
    begin
        m_neg = mean_sum_reg[ppghr_pkg::MEAN_SW-1];
        m_abs = ppghr_pkg::DIV_NW'(m_neg ? -mean_sum_reg : mean_sum_reg);
        if (m_neg)
            m_avg = -$signed({2'b00, div_q}) - $signed((ppghr_pkg::DIV_NW+2)'(div_rnz));
        else
            m_avg = $signed({2'b00, div_q});
    end

    // low-pass accumulate
    logic signed [63:0] lp_sum;
    assign lp_sum = acc_reg + prod_reg;

    // balance check
    logic [31:0]        since_chk;
    logic signed [33:0] bal_d;
    assign since_chk = time_reg - last_chk_reg;
    assign bal_d     = 34'(ir_dc_reg) - 34'(red_dc_reg);

    // tracker
    logic signed [32:0] thr_s;
    logic               peak_now;
    logic signed [31-ppghr_pkg::FRAC_BITS:0] ip;
    assign thr_s    = $signed({9'd0, thresh_reg});
    assign peak_now = (mode_reg == ppghr_pkg::MODE_UP) && !(card_reg > prev_lvl_reg);
    assign ip       = card_reg[31:ppghr_pkg::FRAC_BITS];

    // divider operands
    logic                          div_start;
    logic [ppghr_pkg::DIV_NW-1:0]  div_n;
    logic [31:0]                   div_d;
    always_comb
    begin
        div_start = cmd.div_mean | cmd.div_bpm | cmd.div_avg;
        div_n     = m_abs;
        div_d     = 32'(mean_fill_reg);
        if (cmd.div_bpm)
        begin
            div_n = ppghr_pkg::BPM_NUM;
            div_d = dur_reg;
        end
        else if (cmd.div_avg)
        begin
            div_n = ppghr_pkg::DIV_NW'(bpm_sum_reg);
            div_d = 32'(bpm_fill_reg);
        end
    end

    ppghr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q),
        .rem_nz   (div_rnz)
    );

    logic [23:0] raw_bpm;
    assign raw_bpm = (dur_reg == 32'd0) ? 24'd0 : div_q[23:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= 16'd62259;
            thresh_reg    <= 24'd25600;
            margin_reg    <= 31'd16640000;
            period_reg    <= 16'd500;
            ir_cur_reg    <= 4'd15;
            ir_dc_reg     <= '0;
            red_dc_reg    <= '0;
            for (int i = 0; i < ppghr_pkg::MEAN_DEPTH; i++)
                mean_win_reg[i] <= '0;
            mean_sum_reg  <= '0;
            mean_pos_reg  <= '0;
            mean_fill_reg <= '0;
            lp_prev_reg   <= '0;
            lp_cur_reg    <= '0;
            mode_reg      <= ppghr_pkg::MODE_IDLE;
            prev_lvl_reg  <= '0;
            beat_reg      <= '0;
            prior_reg     <= '0;
            for (int i = 0; i < ppghr_pkg::BPM_DEPTH; i++)
                bpm_win_reg[i] <= '0;
            bpm_pos_reg   <= '0;
            bpm_fill_reg  <= '0;
            bpm_sum_reg   <= '0;
            avg_bpm_reg   <= '0;
            peak_reg      <= '0;
            red_cur_reg   <= ppghr_pkg::RED_RESET;
            last_chk_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the red start code has no register here, so its writes are dropped
            if (cfg_we)
            begin
                case (cfg_idx)
                    ppghr_pkg::REG_DC_ALPHA:   alpha_reg  <= cfg_wdata[15:0];
                    ppghr_pkg::REG_THRESHOLD:  thresh_reg <= cfg_wdata[23:0];
                    ppghr_pkg::REG_MARGIN:     margin_reg <= cfg_wdata;
                    ppghr_pkg::REG_PERIOD:     period_reg <= cfg_wdata[15:0];
                    ppghr_pkg::REG_IR_CURRENT: ir_cur_reg <= cfg_wdata[3:0];
                    default:                   ;
                endcase
            end
            if (cmd.add_ir)
                ir_dc_reg <= dc_nw;
            if (cmd.add_red)
            begin
                red_dc_reg <= dc_nw;
                mean_win_reg[mean_pos_reg] <= ir_ac_reg;
                mean_sum_reg <= msum_ext[ppghr_pkg::MEAN_SW-1:0];
                mean_pos_reg <= (mean_pos_reg == ppghr_pkg::MEAN_PW'(ppghr_pkg::MEAN_DEPTH - 1))
                              ? '0 : mean_pos_reg + 1'b1;
                if (mean_fill_reg < ppghr_pkg::MEAN_FW'(ppghr_pkg::MEAN_DEPTH))
                    mean_fill_reg <= mean_fill_reg + 1'b1;
            end
            if (cmd.lp1)
                lp_prev_reg <= lp_cur_reg;
            if (cmd.lp3)
                lp_cur_reg <= ppghr_pkg::sat32(lp_sum >>> 30);
            if (cmd.card && since_chk >= 32'(period_reg))
            begin
                if (bal_d > $signed({3'd0, margin_reg}) && red_cur_reg < ppghr_pkg::RED_MAX)
                    red_cur_reg <= red_cur_reg + 1'b1;
                else if (-bal_d > $signed({3'd0, margin_reg}) && red_cur_reg != 4'd0)
                    red_cur_reg <= red_cur_reg - 1'b1;
                last_chk_reg <= time_reg;
            end
            if (cmd.track)
            begin
                case (mode_reg)
                    ppghr_pkg::MODE_IDLE:
                    begin
                        if (33'(card_reg) >= thr_s)
                            mode_reg <= ppghr_pkg::MODE_UP;
                        prev_lvl_reg <= card_reg;
                    end
                    ppghr_pkg::MODE_UP:
                    begin
                        if (card_reg > prev_lvl_reg)
                        begin
                            beat_reg     <= time_reg;
                            peak_reg     <= ip[31-ppghr_pkg::FRAC_BITS] ? 24'd0 : 24'(ip);
                            prev_lvl_reg <= card_reg;
                        end
                        else
                        begin
                            prior_reg <= beat_reg;
                            mode_reg  <= ppghr_pkg::MODE_DOWN;
                        end
                    end
                    default:
                    begin
                        if (33'(card_reg) < thr_s)
                            mode_reg <= ppghr_pkg::MODE_IDLE;
                        prev_lvl_reg <= card_reg;
                    end
                endcase
            end
            if (cmd.bpm_upd)
            begin
                bpm_win_reg[bpm_pos_reg] <= raw_bpm;
                bpm_sum_reg <= bpm_sum_reg - ppghr_pkg::BPM_SW'(bpm_win_reg[bpm_pos_reg])
                             + ppghr_pkg::BPM_SW'(raw_bpm);
                bpm_pos_reg <= (bpm_pos_reg == ppghr_pkg::BPM_PW'(ppghr_pkg::BPM_DEPTH - 1))
                             ? '0 : bpm_pos_reg + 1'b1;
                if (bpm_fill_reg < ppghr_pkg::BPM_FW'(ppghr_pkg::BPM_DEPTH))
                    bpm_fill_reg <= bpm_fill_reg + 1'b1;
            end
            if (cmd.avg_fix)
                avg_bpm_reg <= div_q[23:0];
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            raw_ir_reg  <= in_data[15:0];
            raw_red_reg <= in_data[31:16];
            time_reg    <= in_data[63:32];
        end
        if (cmd.mul_ir || cmd.add_ir || cmd.lp1 || cmd.lp2)
            prod_reg <= mul_a * mul_b;
        if (cmd.add_ir)
            ir_ac_reg <= dc_ac;
        if (cmd.add_red)
            red_ac_reg <= dc_ac;
        if (cmd.mean_fix)
            md_reg <= ppghr_pkg::sat32(64'(m_avg) - 64'(ir_ac_reg));
        if (cmd.lp2)
            acc_reg <= prod_reg + 64'sd536870912;
        if (cmd.card)
        begin
            card_reg    <= ppghr_pkg::sat32(64'(lp_prev_reg) + 64'(lp_cur_reg));
            changed_reg <= (since_chk >= 32'(period_reg))
                        && ((bal_d > $signed({3'd0, margin_reg})
                                && red_cur_reg < ppghr_pkg::RED_MAX)
                            || (!(bal_d > $signed({3'd0, margin_reg}))
                                && -bal_d > $signed({3'd0, margin_reg})
                                && red_cur_reg != 4'd0));
        end
        if (cmd.track)
        begin
            pulse_reg <= peak_now;
            dur_reg   <= beat_reg - prior_reg;
        end
        if (cmd.out_load)
            out_data_reg <= {6'd0, changed_reg, red_cur_reg, ir_cur_reg, peak_reg,
                             red_ac_reg, ir_ac_reg, red_dc_reg, ir_dc_reg, card_reg,
                             avg_bpm_reg, pulse_reg};
    end

    assign stat.div_done = div_done;
    assign stat.peak     = peak_now;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/ppg_heart_rate_pipeline_unit.sv =====
// PPG heart rate unit: takes one IR/red sample pair with a millisecond timestamp per
// input word and returns one result word per sample. Each sample runs through a
// leaky-integrator DC remover per channel, a 16-deep moving-mean difference, a
// first-order low-pass and a three-state peak tracker that averages BPM over the last
// ten beats; the red LED current is stepped toward IR/red balance whenever the balance
// period has elapsed and the imbalance exceeds the margin. Samples are handled one at
// a time by a controller and a shared datapath (one 32x32 multiplier, one bit-serial
// 36-step divider). A sample that ends a pulse runs the divider two more times (beat
// rate, then window average). The next sample can be taken in the cycle after the
// result is loaded; while the output is stalled, the controller waits to load it.
// A finished result waits in the output register while the next sample is accepted.
// Configuration writes are always accepted and should be issued only while idle.
`default_nettype none

module ppg_heart_rate_pipeline_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // raw_ir[15:0], raw_red[31:16], time_ms[63:32]
    input  wire logic [63:0]  s_axis_tdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pulse_found[0], heart_rate[24:1], cardiogram[56:25], ir_dc_level[88:57],
    // red_dc_level[120:89], ir_ac_value[152:121], red_ac_value[184:153],
    // peak_level[208:185], led_current_word[216:209], led_current_changed[217]
    output logic [223:0]      m_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // register write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);

    ppghr_pkg::cmd_t  cmd;
    ppghr_pkg::stat_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    ppghr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppghr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/ppghr_chk.sv =====
`default_nettype none

module ppghr_chk (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [223:0] m_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready
);

    // result word stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one sample in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second sample taken while busy");

    // a result never appears right after its sample was taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result too early");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[223:218] == 6'd0)
        else $error("padding bits set");

endmodule

bind ppg_heart_rate_pipeline_unit ppghr_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
